[rtl/bsm_pkg.sv]
package bsm_pkg;

  // Item kind carried on the input tuser
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_PRG   = 2'd2,
    MODE_CHR   = 2'd3
  } mode_e;

  // Register decode: {addr[14:13], addr[0]} for addresses with bit 15 set
  typedef enum logic [2:0] {
    REG_BANK_SEL   = 3'b000,  // 0x8000
    REG_BANK_DATA  = 3'b001,  // 0x8001
    REG_MIRROR     = 3'b010,  // 0xA000
    REG_RAM_PROT   = 3'b011,  // 0xA001
    REG_IRQ_LATCH  = 3'b100,  // 0xC000
    REG_IRQ_RELOAD = 3'b101,  // 0xC001
    REG_IRQ_DIS    = 3'b110,  // 0xE000
    REG_IRQ_EN     = 3'b111   // 0xE001
  } reg_e;

  localparam int unsigned NumBanks = 8;

  localparam logic [7:0] PrgFixed2nd = 8'h3E;
  localparam logic [7:0] PrgFixedLast = 8'h3F;
  localparam logic [7:0] PrgMask = 8'h3F;

  // Bank register contents after reset, entry 0 in the low byte
  localparam logic [NumBanks-1:0][7:0] BankRegsReset = {
    8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0
  };

  typedef struct packed {
    logic [7:0]                 sel;   // bank select register
    logic [NumBanks-1:0][7:0]   regs;  // R0..R7
  } bank_state_t;

  typedef struct packed {
    logic mirror;
    logic irq;
  } status_t;

endpackage

[rtl/bsm_core.sv]
module bsm_core
  import bsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  mode_e       mode_i,
  input  logic [15:0] cpu_addr_i,
  input  logic [7:0]  write_data_i,
  output bank_state_t bank_state_o,
  output status_t     status_o       // values after this transaction
);

  logic [7:0]               bank_sel_q, bank_sel_d;
  logic [NumBanks-1:0][7:0] bank_regs_q, bank_regs_d;
  logic                     mirror_q, mirror_d;
  logic [7:0]               ram_prot_q, ram_prot_d;
  logic [7:0]               reload_q, reload_d;
  logic [8:0]               counter_q, counter_d;
  logic                     irq_en_q, irq_en_d;
  logic                     pending_q, pending_d;
  logic                     direct_q, direct_d;
  logic                     latched_q, latched_d;
  logic [8:0]               counter_dec;
  reg_e                     reg_sel;

  assign reg_sel     = reg_e'({cpu_addr_i[14:13], cpu_addr_i[0]});
  assign counter_dec = counter_q - 9'd1;

  always_comb begin
    bank_sel_d  = bank_sel_q;
    bank_regs_d = bank_regs_q;
    mirror_d    = mirror_q;
    ram_prot_d  = ram_prot_q;
    reload_d    = reload_q;
    counter_d   = counter_q;
    irq_en_d    = irq_en_q;
    pending_d   = pending_q;
    direct_d    = direct_q;
    latched_d   = latched_q;
    if (en_i) begin
      case (mode_i)
        MODE_WRITE: begin
          if (cpu_addr_i[15]) begin
            unique case (reg_sel)
              REG_BANK_SEL:  bank_sel_d = write_data_i;
              REG_BANK_DATA: bank_regs_d[bank_sel_q[2:0]] = write_data_i;
              REG_MIRROR:    mirror_d = write_data_i[0];
              REG_RAM_PROT:  ram_prot_d = write_data_i;
              REG_IRQ_LATCH: begin
                reload_d = write_data_i;
                if (direct_q) begin
                  counter_d = {1'b0, write_data_i};
                  latched_d = 1'b0;
                end else begin
                  latched_d = 1'b1;
                end
              end
              REG_IRQ_RELOAD: counter_d = {1'b0, reload_q};
              REG_IRQ_DIS: begin
                irq_en_d  = 1'b0;
                pending_d = 1'b0;
                direct_d  = 1'b1;
              end
              REG_IRQ_EN: begin
                irq_en_d = 1'b1;
                if (latched_q) begin
                  counter_d = {1'b0, reload_q};
                end
              end
              default: ;
            endcase
          end
        end
        MODE_TICK: begin
          direct_d = 1'b0;
          // counter parks at -1
          if (!counter_q[8]) begin
            counter_d = counter_dec;
            if (counter_dec[8] && irq_en_q) begin
              pending_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q  <= '0;
      bank_regs_q <= BankRegsReset;
      mirror_q    <= 1'b0;
      ram_prot_q  <= '0;
      reload_q    <= '0;
      counter_q   <= '0;
      irq_en_q    <= 1'b0;
      pending_q   <= 1'b0;
      direct_q    <= 1'b0;
      latched_q   <= 1'b0;
    end else begin
      bank_sel_q  <= bank_sel_d;
      bank_regs_q <= bank_regs_d;
      mirror_q    <= mirror_d;
      ram_prot_q  <= ram_prot_d;
      reload_q    <= reload_d;
      counter_q   <= counter_d;
      irq_en_q    <= irq_en_d;
      pending_q   <= pending_d;
      direct_q    <= direct_d;
      latched_q   <= latched_d;
    end
  end

  assign bank_state_o.sel  = bank_sel_q;
  assign bank_state_o.regs = bank_regs_q;
  assign status_o.mirror   = mirror_d;
  assign status_o.irq      = pending_d;

endmodule

[rtl/bsm_xlate.sv]
module bsm_xlate
  import bsm_pkg::*;
(
  input  mode_e       mode_i,
  input  logic [15:0] cpu_addr_i,
  input  logic [12:0] ppu_addr_i,
  input  bank_state_t bank_state_i,
  output logic [7:0]  bank_o
);

  logic [7:0] prg_bank;
  logic [7:0] chr_bank;
  logic [2:0] chr_slot;
  logic       prg_swap;

  assign prg_swap = bank_state_i.sel[6];
  assign chr_slot = ppu_addr_i[12:10] ^ {bank_state_i.sel[7], 2'b00};

  always_comb begin
    prg_bank = '0;
    if (cpu_addr_i[15]) begin
      case (cpu_addr_i[14:13])
        2'd0:    prg_bank = prg_swap ? PrgFixed2nd : bank_state_i.regs[6];
        2'd1:    prg_bank = bank_state_i.regs[7];
        2'd2:    prg_bank = prg_swap ? bank_state_i.regs[6] : PrgFixed2nd;
        default: prg_bank = PrgFixedLast;
      endcase
      prg_bank = prg_bank & PrgMask;
    end
  end

  // 2K pairs in the low half, 1K banks in the high half
  always_comb begin
    case (chr_slot)
      3'd0:    chr_bank = {bank_state_i.regs[0][7:1], 1'b0};
      3'd1:    chr_bank = {bank_state_i.regs[0][7:1], 1'b1};
      3'd2:    chr_bank = {bank_state_i.regs[1][7:1], 1'b0};
      3'd3:    chr_bank = {bank_state_i.regs[1][7:1], 1'b1};
      3'd4:    chr_bank = bank_state_i.regs[2];
      3'd5:    chr_bank = bank_state_i.regs[3];
      3'd6:    chr_bank = bank_state_i.regs[4];
      default: chr_bank = bank_state_i.regs[5];
    endcase
  end

  always_comb begin
    case (mode_i)
      MODE_PRG: bank_o = prg_bank;
      MODE_CHR: bank_o = chr_bank;
      default:  bank_o = '0;
    endcase
  end

endmodule

[rtl/bank_switch_mapper_with_scanline_irq.sv]
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: mode; tdata: cpu_addr, write_data,
//                                               ppu_addr
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: bank, mirroring, irq_line
//
// One transaction per cycle sustained while the output is not stalled; an accepted
// item sits in the input register, then its result moves to the output register,
// where it is ready to be taken. Each item sees all earlier writes and ticks.
// Reset (async, active low) restores the power-up bank table and clears IRQ
// state. A stalled output holds the pipe; the input register still fills, so
// one item waits behind one pending result.
module bank_switch_mapper_with_scanline_irq
  import bsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [15:0] cpu_addr, [23:16] write_data,
                                      // [36:24] ppu_addr, [39:37] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] bank, [8] mirroring, [9] irq_line,
                                      // [15:10] zero
);

  // Input register
  logic        in_valid_q, in_valid_d;
  mode_e       mode_q;
  logic [15:0] cpu_addr_q;
  logic [7:0]  write_data_q;
  logic [12:0] ppu_addr_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  bank_q;
  logic        mirror_q;
  logic        irq_q;

  logic        advance;   // output slot free this cycle
  logic        fire;      // item in input register is processed
  logic        in_load;

  bank_state_t bank_state;
  status_t     status;
  logic [7:0]  bank;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      mode_q       <= mode_e'(s_axis_tuser);
      cpu_addr_q   <= s_axis_tdata[15:0];
      write_data_q <= s_axis_tdata[23:16];
      ppu_addr_q   <= s_axis_tdata[36:24];
    end
  end

  // Mapper state: register writes and scanline ticks
  bsm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (fire),
    .mode_i       (mode_q),
    .cpu_addr_i   (cpu_addr_q),
    .write_data_i (write_data_q),
    .bank_state_o (bank_state),
    .status_o     (status)
  );

  // Program / pattern address translation off the current bank state
  bsm_xlate u_xlate (
    .mode_i       (mode_q),
    .cpu_addr_i   (cpu_addr_q),
    .ppu_addr_i   (ppu_addr_q),
    .bank_state_i (bank_state),
    .bank_o       (bank)
  );

  always_ff @(posedge clk_i) begin
    if (fire) begin
      bank_q   <= bank;
      mirror_q <= status.mirror;
      irq_q    <= status.irq;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, irq_q, mirror_q, bank_q};

endmodule

[verif/tb_bank_switch_mapper_with_scanline_irq.sv]
`timescale 1ns / 100ps

module tb_bank_switch_mapper_with_scanline_irq;
  import bsm_pkg::*;

  // Generous bound: the slowest phases stay well within it
  localparam int unsigned CycleLimit = 400000;

  // One expected output transaction: translated bank plus status bits
  typedef struct packed {
    logic [7:0] bank;
    logic       mirror;
    logic       irq;
  } mapper_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [15:0] cpu_addr, [23:16] write_data,
                                    // [36:24] ppu_addr, [39:37] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] bank, [8] mirroring, [9] irq_line,
                                    // [15:10] zero

  // Idling knobs, percent of cycles
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  mapper_out_t predicted_outputs[$];

  // Shadow copy of the mapper registers
  logic [7:0] bank_sel;
  logic [7:0] bank_reg [NumBanks];
  logic       mirror_st;
  logic [7:0] prot_st;
  logic [7:0] irq_latch;
  logic [8:0] irq_count;     // two's complement, -1..255
  logic       irq_armed;
  logic       irq_flag;
  logic       direct_load;
  logic       latch_loaded;

  bank_switch_mapper_with_scanline_irq dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, predicted_outputs.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge only
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Updates the shadow state for one accepted item and returns the output
  // that the block must produce for it (status is taken after the update).
  function automatic mapper_out_t mapper_step(input mode_e m, input logic [15:0] caddr,
                                              input logic [7:0] data,
                                              input logic [12:0] paddr);
    mapper_out_t r;
    logic [7:0]  v;
    logic [2:0]  slot;
    v = 8'h00;
    case (m)
      MODE_WRITE: begin
        // Anything below 0x8000 is not a mapper register
        if (caddr[15]) begin
          case (reg_e'({caddr[14:13], caddr[0]}))
            REG_BANK_SEL:   bank_sel = data;
            REG_BANK_DATA:  bank_reg[bank_sel[2:0]] = data;
            REG_MIRROR:     mirror_st = data[0];
            REG_RAM_PROT:   prot_st = data;          // no visible effect
            REG_IRQ_LATCH: begin
              irq_latch = data;
              latch_loaded = 1'b1;
              // After a disable and until the next tick the latch goes straight into the counter
              if (direct_load) begin
                irq_count = {1'b0, data};
                latch_loaded = 1'b0;
              end
            end
            REG_IRQ_RELOAD: irq_count = {1'b0, irq_latch};
            REG_IRQ_DIS: begin
              irq_armed = 1'b0;
              irq_flag = 1'b0;
              direct_load = 1'b1;
            end
            REG_IRQ_EN: begin
              irq_armed = 1'b1;
              if (latch_loaded) irq_count = {1'b0, irq_latch};
            end
            default: ;
          endcase
        end
      end
      MODE_TICK: begin
        direct_load = 1'b0;
        // Counter parks at -1; only the step from 0 to -1 raises the flag
        if (!irq_count[8]) begin
          irq_count = irq_count - 9'd1;
          if (irq_count[8] && irq_armed) irq_flag = 1'b1;
        end
      end
      MODE_PRG: begin
        if (caddr[15]) begin
          case (caddr[14:13])
            2'd0:    v = bank_sel[6] ? PrgFixed2nd : bank_reg[6];
            2'd1:    v = bank_reg[7];
            2'd2:    v = bank_sel[6] ? bank_reg[6] : PrgFixed2nd;
            default: v = PrgFixedLast;
          endcase
          v = v & PrgMask;
        end
      end
      default: begin
        // 1K slot, halves swapped by select bit 7; low four slots are 2K pairs
        slot = paddr[12:10] ^ {bank_sel[7], 2'b00};
        case (slot)
          3'd0:    v = bank_reg[0] & 8'hFE;
          3'd1:    v = bank_reg[0] | 8'h01;
          3'd2:    v = bank_reg[1] & 8'hFE;
          3'd3:    v = bank_reg[1] | 8'h01;
          default: v = bank_reg[slot - 3'd2];
        endcase
      end
    endcase
    r.bank = v;
    r.mirror = mirror_st;
    r.irq = irq_flag;
    return r;
  endfunction

  // Checks each output transaction against the oldest prediction, then
  // predicts for the input transaction of the same edge.
  always @(posedge clk_i) begin : scoreboard
    mapper_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = predicted_outputs.pop_front();
          if (m_axis_tdata[7:0] !== want.bank) begin
            mismatches++;
            $display("%0t: bank mismatch, expected %h, actual %h", $time, want.bank,
                     m_axis_tdata[7:0]);
          end
          if (m_axis_tdata[8] !== want.mirror) begin
            mismatches++;
            $display("%0t: mirroring mismatch, expected %b, actual %b", $time, want.mirror,
                     m_axis_tdata[8]);
          end
          if (m_axis_tdata[9] !== want.irq) begin
            mismatches++;
            $display("%0t: irq_line mismatch, expected %b, actual %b", $time, want.irq,
                     m_axis_tdata[9]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_outputs.push_back(mapper_step(mode_e'(s_axis_tuser), s_axis_tdata[15:0],
                                                s_axis_tdata[23:16], s_axis_tdata[36:24]));
      end
    end
  end

  // Drives one input transaction; returns at the edge that accepts it.
  // valid is left high so back-to-back items never drop it in between.
  task automatic send_item(input mode_e m, input logic [15:0] caddr, input logic [7:0] data,
                           input logic [12:0] paddr);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m;
    s_axis_tdata <= {3'b000, paddr, data, caddr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender holds off until every predicted result is out, plus pipe latency
  task automatic wait_for_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register address with random don't-care bits 12..1
  function automatic logic [15:0] reg_addr(input reg_e r);
    logic [11:0] fill;
    fill = 12'($urandom);
    return {1'b1, r[2:1], fill, r[0]};
  endfunction

  task automatic send_random_item();
    int unsigned k;
    reg_e        r;
    logic [15:0] caddr;
    logic [7:0]  data;
    k = $urandom_range(99);
    r = reg_e'($urandom_range(7));
    caddr = ($urandom_range(9) == 0) ? 16'($urandom) : reg_addr(r);
    // Short latch values keep the interrupt firing often
    data = (r == REG_IRQ_LATCH && $urandom_range(1)) ? 8'($urandom_range(7)) : 8'($urandom);
    if (k < 40)      send_item(MODE_WRITE, caddr, data, 13'($urandom));
    else if (k < 62) send_item(MODE_TICK, 16'($urandom), 8'($urandom), 13'($urandom));
    else if (k < 80) send_item(MODE_PRG, 16'($urandom), 8'($urandom), 13'($urandom));
    else             send_item(MODE_CHR, 16'($urandom), 8'($urandom), 13'($urandom));
  endtask

  // Power-up table, program slots, swap and inversion, ignored low writes
  task automatic test_bank_translation();
    send_item(MODE_CHR, 16'h0000, 8'h00, 13'h0000);    // R0 even half
    send_item(MODE_CHR, 16'h0000, 8'h00, 13'h1C00);    // R5
    send_item(MODE_PRG, 16'h8000, 8'h00, 13'h0000);    // R6
    send_item(MODE_PRG, 16'hE000, 8'h00, 13'h0000);    // fixed last bank
    send_item(MODE_PRG, 16'h7FFF, 8'h00, 13'h0000);    // below window: 0
    send_item(MODE_WRITE, 16'h7FFF, 8'hFF, 13'h1FFF);  // below window: ignored
    send_item(MODE_WRITE, 16'h8000, 8'hC7, 13'h0000);  // swap + invert, select R7
    send_item(MODE_WRITE, 16'h8001, 8'hFF, 13'h0000);
    send_item(MODE_PRG, 16'hA000, 8'h00, 13'h0000);    // R7 masked to 6 bits
    send_item(MODE_PRG, 16'h8000, 8'h00, 13'h0000);    // swapped: fixed 2nd last
    send_item(MODE_WRITE, 16'h8000, 8'h80, 13'h0000);  // invert only, select R0
    send_item(MODE_WRITE, 16'h8001, 8'hFF, 13'h0000);
    send_item(MODE_CHR, 16'hFFFF, 8'hFF, 13'h1000);    // inverted -> R0 even half
    send_item(MODE_CHR, 16'hFFFF, 8'hFF, 13'h1FFF);    // inverted -> R1 odd half
    send_item(MODE_WRITE, 16'hA000, 8'hFF, 13'h0000);  // mirroring on
    send_item(MODE_WRITE, 16'hA001, 8'hFF, 13'h0000);
  endtask

  // Counter underflow, parking at -1, direct load, reload and latch paths
  task automatic test_irq_counter();
    send_item(MODE_WRITE, 16'hFFFF, 8'h00, 13'h0000);  // enable, no latch yet
    send_item(MODE_TICK, 16'h0000, 8'h00, 13'h0000);   // 0 -> -1: pending
    send_item(MODE_TICK, 16'h0000, 8'h00, 13'h0000);   // parked at -1
    send_item(MODE_WRITE, 16'hE000, 8'h00, 13'h0000);  // disable, clear, direct
    send_item(MODE_WRITE, 16'hC000, 8'h02, 13'h0000);  // direct load of 2
    send_item(MODE_WRITE, 16'hE001, 8'h00, 13'h0000);
    repeat (3) send_item(MODE_TICK, 16'h0000, 8'h00, 13'h0000);
    send_item(MODE_WRITE, 16'hC001, 8'h00, 13'h0000);  // reload; pending stays
    send_item(MODE_WRITE, 16'hC000, 8'hFF, 13'h0000);  // latched only
    send_item(MODE_WRITE, 16'hE001, 8'h00, 13'h0000);  // enable loads 255
    send_item(MODE_WRITE, 16'hE000, 8'h00, 13'h0000);
  endtask

  // Mostly single random items, with interrupt set-up sequences mixed in
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(1)) send_item(MODE_WRITE, reg_addr(REG_IRQ_DIS), 8'($urandom),
                                         13'($urandom));
        send_item(MODE_WRITE, reg_addr(REG_IRQ_LATCH), 8'($urandom_range(6)), 13'($urandom));
        if ($urandom_range(1)) send_item(MODE_WRITE, reg_addr(REG_IRQ_RELOAD), 8'($urandom),
                                         13'($urandom));
        send_item(MODE_WRITE, reg_addr(REG_IRQ_EN), 8'($urandom), 13'($urandom));
        n_ticks = $urandom_range(1, 9);
        repeat (n_ticks) begin
          if ($urandom_range(2) == 0) send_random_item();
          send_item(MODE_TICK, 16'($urandom), 8'($urandom), 13'($urandom));
        end
        sent += 4 + n_ticks;
      end else begin
        send_random_item();
        sent++;
      end
    end
  endtask

  initial begin
    // Shadow state at power-up
    bank_sel = 8'h00;
    for (int i = 0; i < NumBanks; i++) bank_reg[i] = BankRegsReset[i];
    mirror_st = 1'b0;
    prot_st = 8'h00;
    irq_latch = 8'h00;
    irq_count = 9'd0;
    irq_armed = 1'b0;
    irq_flag = 1'b0;
    direct_load = 1'b0;
    latch_loaded = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_bank_translation();
    test_irq_counter();
    wait_for_drain();

    test_random_traffic(270);
    wait_for_drain();

    src_idle_pct = 78;
    test_random_traffic(260);
    wait_for_drain();

    src_idle_pct = 0;
    sink_stall_pct = 78;
    test_random_traffic(260);
    wait_for_drain();

    src_idle_pct = 12;
    sink_stall_pct = 12;
    test_random_traffic(260);
    wait_for_drain();

    // Catch any stray result after the last expected one
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
